[hw/rtl/bilateral_filter_5x5_assert.svh]
// ----------------------------------------------------------------------------
// bilateral_filter_5x5 assertion macros
// Shared property forms for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef BILATERAL_FILTER_5X5_ASSERT_SVH
`define BILATERAL_FILTER_5X5_ASSERT_SVH

// Antecedent implies consequent on the next clock edge.
`define BF5_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

// Antecedent implies consequent on the same clock edge.
`define BF5_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

`endif

[hw/rtl/bf5_pkg.sv]
// ----------------------------------------------------------------------------
// bf5_pkg
// Shared constants, weight table builders and controller/datapath structs.
// ----------------------------------------------------------------------------
package bf5_pkg;

    localparam int MAX_WIDTH_DEF   = 256;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int DIM_W           = 9;
    localparam int PIX_W           = 8;
    localparam int MIN_SIZE        = 8;
    localparam int MAX_HEIGHT      = 256;
    localparam int SPATIAL_DEN     = 288;
    localparam int RANGE_DEN       = 800;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [31:0] wtab_range_t [256];
    typedef logic [31:0] wtab_spatial_t [6];

    // Commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic [2:0] sel;
        logic       rd_capture;
        logic       commit;
        logic       tap_clear;
        logic       tap_issue;
        logic       div_load;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic drop;
        logic emit;
        logic out_busy;
    } status_t;

    // exp(-f / 2^30) in Q30 by a 21-term series
    function automatic logic [63:0] exp_frac_q30(input logic [63:0] f);
        logic signed [65:0] sum;
        logic [63:0] term;
        int k;
        sum  = 66'(ONE_Q30);
        term = ONE_Q30;
        for (k = 1; k <= 20; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if (k % 2 == 1)
                sum = sum - $signed({2'b00, term});
            else
                sum = sum + $signed({2'b00, term});
        end
        exp_frac_q30 = (sum > 0) ? sum[63:0] : 64'd0;
    endfunction

    // Apply integer part and round to Q1.wfrac
    function automatic logic [63:0] weight_from(input int n, input logic [63:0] f,
                                                input int wfrac);
        logic [63:0] v;
        logic [63:0] e1;
        int i;
        v  = exp_frac_q30(f);
        e1 = exp_frac_q30(ONE_Q30);
        for (i = 0; i < n; i++) begin
            if (v != 64'd0)
                v = (v * e1) >> 30;
        end
        weight_from = (v + (64'd1 << (29 - wfrac))) >> (30 - wfrac);
    endfunction

    function automatic logic [63:0] spatial_weight(input int num, input int wfrac);
        logic [63:0] f;
        f = (64'(num % SPATIAL_DEN) << 30) / SPATIAL_DEN;
        spatial_weight = weight_from(num / SPATIAL_DEN, f, wfrac);
    endfunction

    function automatic logic [63:0] range_weight(input int num, input int wfrac);
        logic [63:0] f;
        f = (64'(num % RANGE_DEN) << 30) / RANGE_DEN;
        range_weight = weight_from(num / RANGE_DEN, f, wfrac);
    endfunction

    function automatic wtab_range_t build_range_tab(input int wfrac);
        wtab_range_t tab;
        int i;
        for (i = 0; i < 256; i++)
            tab[i] = 32'(range_weight(i * i, wfrac));
        build_range_tab = tab;
    endfunction

    function automatic wtab_spatial_t build_spatial_tab(input int wfrac);
        wtab_spatial_t tab;
        tab[0] = 32'(spatial_weight(0, wfrac));
        tab[1] = 32'(spatial_weight(1, wfrac));
        tab[2] = 32'(spatial_weight(2, wfrac));
        tab[3] = 32'(spatial_weight(4, wfrac));
        tab[4] = 32'(spatial_weight(5, wfrac));
        tab[5] = 32'(spatial_weight(8, wfrac));
        build_spatial_tab = tab;
    endfunction

    // Distance class of a tap from its row and column in the window
    function automatic logic [2:0] tap_class(input logic [2:0] dr, input logic [2:0] dc);
        logic [2:0] ar;
        logic [2:0] ac;
        ar = (dr > 3'd2) ? dr - 3'd2 : 3'd2 - dr;
        ac = (dc > 3'd2) ? dc - 3'd2 : 3'd2 - dc;
        if (ar == 3'd2 && ac == 3'd2)
            tap_class = 3'd5;
        else if (ar == 3'd2 || ac == 3'd2)
            tap_class = (ar == 3'd1 || ac == 3'd1) ? 3'd4 : 3'd3;
        else if (ar == 3'd1 && ac == 3'd1)
            tap_class = 3'd2;
        else if (ar == 3'd1 || ac == 3'd1)
            tap_class = 3'd1;
        else
            tap_class = 3'd0;
    endfunction

endpackage

[hw/rtl/bf5_ram.sv]
// ----------------------------------------------------------------------------
// bf5_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/bf5_ctrl.sv]
// ----------------------------------------------------------------------------
// bf5_ctrl
// Sequencer: line reads, window commit, tap loop, division, output load.
// ----------------------------------------------------------------------------
module bf5_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bf5_pkg::status_t status,
    output bf5_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RD     = 7'b0000010,
        ST_RDW    = 7'b0000100,
        ST_COMMIT = 7'b0001000,
        ST_CALC   = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_LOAD   = 7'b1000000
    } state_t;

    localparam logic [4:0] TAP_LAST   = 5'd24;
    localparam logic [4:0] CALC_LAST  = 5'd26;
    localparam logic [4:0] DIV_LAST   = 5'd8;
    localparam logic [4:0] ROW_LAST   = 5'd4;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    // Advance state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.drop)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.sel    = cnt_reg[2:0];
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                cmd.sel        = cnt_reg[2:0];
                cmd.rd_capture = 1'b1;
                if (cnt_reg == ROW_LAST)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_RD;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit    = 1'b1;
                cmd.tap_clear = 1'b1;
                cnt_next      = '0;
                state_next    = status.emit ? ST_CALC : ST_IDLE;
            end
            ST_CALC:
            begin
                cmd.tap_issue = (cnt_reg <= TAP_LAST);
                if (cnt_reg == CALC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                cmd.div_load = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_LOAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/bf5_dp.sv]
// ----------------------------------------------------------------------------
// bf5_dp
// Datapath: position counters, line store, window, weighted sums, divider.
// ----------------------------------------------------------------------------
module bf5_dp #(
    parameter int MAX_WIDTH   = bf5_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = bf5_pkg::WEIGHT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bf5_pkg::cmd_t              cmd,
    output bf5_pkg::status_t           status,
    input  logic [bf5_pkg::PIX_W-1:0]  in_pixel,
    input  logic                       in_flush,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bf5_pkg::DIM_W-1:0]  cfg_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bf5_pkg::PIX_W-1:0]  out_pixel,
    output logic                       out_last
);

    localparam int DW      = bf5_pkg::DIM_W;
    localparam int PW      = bf5_pkg::PIX_W;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int DEPTH   = 4 * (2 ** CW);
    localparam int WLIM    = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int WW      = 2 * WEIGHT_BITS;
    localparam int WSUM_W  = WW + 5;
    localparam int ACC_W   = WW + PW + 5;
    localparam int WFRAC   = WEIGHT_BITS - 1;

    localparam bf5_pkg::wtab_range_t   RANGE_TAB   = bf5_pkg::build_range_tab(WFRAC);
    localparam bf5_pkg::wtab_spatial_t SPATIAL_TAB = bf5_pkg::build_spatial_tab(WFRAC);

    // Frame geometry and raster positions
    logic [DW-1:0] width_reg, height_reg;
    logic [DW-1:0] in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic [DW-1:0] cfg_sat;

    // Window: win[h][row], h = 0 newest column
    logic [PW-1:0] win_reg [5][5];
    logic [PW-1:0] col_reg [5];
    logic [PW-1:0] px_reg;

    // Line store port
    logic                    mem_we;
    logic [$clog2(DEPTH)-1:0] mem_addr;
    logic [PW-1:0]           mem_rdata;

    // Tap pipeline
    logic [2:0]        dr_reg, dc_reg;
    logic              v1_reg, v2_reg;
    logic [WW-1:0]     w1_reg;
    logic [PW-1:0]     p1_reg;
    logic [WW+PW-1:0]  wp_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [ACC_W-1:0]  acc_reg;

    // Divider
    logic [ACC_W-1:0]  rem_reg, dvs_reg;
    logic [PW-1:0]     quo_reg;

    // Output register
    logic          out_valid_reg;
    logic [PW-1:0] out_pixel_reg;
    logic          out_last_reg;

    // Row addressed by the current read step
    logic signed [DW+1:0] q_s;
    logic [DW-1:0]        q_row;
    logic [CW-1:0]        col_idx;

    assign col_idx = CW'(in_col_reg);
    assign q_s     = $signed({2'b00, in_row_reg}) - 11'sd4 + $signed({8'b0, cmd.sel});

    always_comb
    begin
        if (q_s < 0)
            q_row = '0;
        else if (q_s > $signed({2'b00, height_reg - 9'd1}))
            q_row = height_reg - 9'd1;
        else
            q_row = q_s[DW-1:0];
    end

    // Line store read during the row steps, write at commit
    assign mem_we   = cmd.commit && (in_row_reg < height_reg);
    assign mem_addr = cmd.commit ? {in_row_reg[1:0], col_idx} : {q_row[1:0], col_idx};

    bf5_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (px_reg),
        .rdata (mem_rdata)
    );

    // Saturate a written size
    always_comb
    begin
        if (cfg_data < 9'(bf5_pkg::MIN_SIZE))
            cfg_sat = 9'(bf5_pkg::MIN_SIZE);
        else if (cfg_index == bf5_pkg::REG_WIDTH && cfg_data > 9'(WLIM))
            cfg_sat = 9'(WLIM);
        else if (cfg_index == bf5_pkg::REG_HEIGHT && cfg_data > 9'(bf5_pkg::MAX_HEIGHT))
            cfg_sat = 9'(bf5_pkg::MAX_HEIGHT);
        else
            cfg_sat = cfg_data;
    end

    // Status toward the controller
    logic frame_last;
    assign frame_last = (out_row_reg == height_reg - 9'd1) &&
                        (out_col_reg == width_reg - 9'd1);
    assign status.drop     = (in_row_reg < height_reg) && in_flush;
    assign status.emit     = ((in_row_reg > 9'd2) ||
                              (in_row_reg == 9'd2 && in_col_reg >= 9'd2)) &&
                             (out_row_reg < height_reg);
    assign status.out_busy = out_valid_reg && !out_ready;

    // Output valid: set on load, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Counters and geometry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 9'(WLIM);
            height_reg    <= 9'(bf5_pkg::MAX_HEIGHT);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bf5_pkg::REG_WIDTH)
                    width_reg <= cfg_sat;
                else
                    height_reg <= cfg_sat;
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (cmd.commit)
            begin
                if (in_col_reg + 9'd1 >= width_reg)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 9'd1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 9'd1;
                end
            end
            else if (cmd.out_load)
            begin
                if (frame_last)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else if (out_col_reg + 9'd1 >= width_reg)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 9'd1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 9'd1;
                end
            end
        end
    end

    // Window shift at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < 5; h++)
                for (int r = 0; r < 5; r++)
                    win_reg[h][r] <= '0;
        end
        else if (cmd.commit)
        begin
            for (int h = 1; h < 5; h++)
                win_reg[h] <= win_reg[h-1];
            win_reg[0] <= col_reg;
        end
    end

    // Hold the pixel and build the new column
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= in_pixel;
        end
        if (cmd.rd_capture)
        begin
            col_reg[cmd.sel] <= (q_row == in_row_reg) ? px_reg : mem_rdata;
        end
    end

    // Tap selection with border replication
    logic signed [DW+1:0] k_s, kc_s, h_s;
    logic [2:0]           h_idx;
    logic [PW-1:0]        tap_p, centre;
    logic [PW-1:0]        diff;
    logic [WEIGHT_BITS-1:0] sw, rw;

    assign centre = win_reg[2][2];
    assign k_s    = $signed({2'b00, out_col_reg}) + $signed({8'b0, dc_reg}) - 11'sd2;

    always_comb
    begin
        if (k_s < 0)
            kc_s = '0;
        else if (k_s > $signed({2'b00, width_reg - 9'd1}))
            kc_s = $signed({2'b00, width_reg - 9'd1});
        else
            kc_s = k_s;
        h_s = $signed({2'b00, out_col_reg}) + 11'sd2 - kc_s;
        h_idx = (h_s > 11'sd4) ? 3'd4 : h_s[2:0];
    end

    assign tap_p = win_reg[h_idx][dr_reg];
    assign diff  = (tap_p > centre) ? tap_p - centre : centre - tap_p;
    assign sw    = SPATIAL_TAB[bf5_pkg::tap_class(dr_reg, dc_reg)][WEIGHT_BITS-1:0];
    assign rw    = RANGE_TAB[diff][WEIGHT_BITS-1:0];

    // Tap pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dr_reg <= '0;
            dc_reg <= '0;
        end
        else if (cmd.tap_clear)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dr_reg <= '0;
            dc_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
            if (cmd.tap_issue)
            begin
                if (dc_reg == 3'd4)
                begin
                    dc_reg <= '0;
                    dr_reg <= dr_reg + 3'd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 3'd1;
                end
            end
        end
    end

    // Weight, product, sums, divider and output register
    always_ff @(posedge clk)
    begin
        w1_reg <= WW'(sw) * WW'(rw);
        p1_reg <= tap_p;
        wp_reg <= (WW+PW)'(w1_reg) * (WW+PW)'(p1_reg);
        if (cmd.tap_clear)
        begin
            wsum_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (v1_reg)
                wsum_reg <= wsum_reg + WSUM_W'(w1_reg);
            if (v2_reg)
                acc_reg <= acc_reg + ACC_W'(wp_reg);
        end
        if (cmd.div_load)
        begin
            rem_reg <= acc_reg;
            dvs_reg <= ACC_W'(wsum_reg) << 7;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_reg <= rem_reg - dvs_reg;
                quo_reg <= {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[PW-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.out_load)
        begin
            out_pixel_reg <= quo_reg;
            out_last_reg  <= frame_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/bilateral_filter_5x5.sv]
// ----------------------------------------------------------------------------
// bilateral_filter_5x5
// 5x5 bilateral filter over an 8-bit grayscale raster stream.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata=pixel, tuser=flush
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata=filtered, tlast=last_of_frame
//   cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// An item with no result runs 5 line-store reads, each an address and a capture
// step, through its single RAM port, plus accept and commit; one with a result
// adds the shared weight multiplier loop, the divider and one output load. An
// ignored flush item is consumed in the idle state alone. Reset needs no
// clearing pass. A stalled output holds the output register; the next item is
// taken meanwhile, and its result waits in the load step until the register frees.
// ----------------------------------------------------------------------------
module bilateral_filter_5x5 #(
    parameter int MAX_WIDTH   = bf5_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = bf5_pkg::WEIGHT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] pixel
    input  logic       s_axis_tuser,   // [0] flush
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] filtered
    output logic       m_axis_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data
);

    bf5_pkg::cmd_t    cmd;
    bf5_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer
    bf5_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    bf5_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_pixel  (s_axis_tdata),
        .in_flush  (s_axis_tuser),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

[hw/rtl/bf5_checker.sv]
// ----------------------------------------------------------------------------
// bf5_checker
// Port-level checks on the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bilateral_filter_5x5_assert.svh"

module bf5_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       cfg_index,
    input logic [8:0] cfg_data
);

    // Stalled result holds
    `BF5_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // A pixel item keeps the block busy on the next cycle
    `BF5_ASSERT_NEXT(a_busy_after_pixel, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready)

    // A new result only appears after a busy cycle
    `BF5_ASSERT_SAME(a_result_after_work, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind bilateral_filter_5x5 bf5_checker u_bf5_checker (.*);
